// File: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the sorted priority queue
// Capacity, derived widths, result status codes and the command and status
// bundles that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic ld_item;    // capture key and payload, set index to the count
    logic rd_en;      // read the slot just below the index
    logic shift_wr;   // move the read entry one slot back, step the index
    logic new_wr;     // write the new entry at the index
    logic cnt_inc;
    logic cnt_dec;
    logic res_done;   // push finished
    logic res_full;
    logic res_empty;
    logic res_pop;    // pop finished, read data carries the entry
  } spq_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_one;    // index will reach zero after this shift
    logic rd_le;      // read key is not larger than the new key
  } spq_sts_t;

endpackage

// File: hw/rtl/spq_dp.sv
// ----------------------------------------------------------------------------
// spq_dp: datapath of the sorted priority queue
// Entry memory with one write and one registered read port, the entry count,
// the insertion index, the captured item and the result registers.
// ----------------------------------------------------------------------------
module spq_dp
  import spq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  spq_cmd_t                cmd_i,
  output spq_sts_t                sts_o,
  input  logic signed [31:0]      key_i,
  input  logic        [31:0]      payload_i,
  output logic                    done_o,
  output logic        [1:0]       status_o,
  output logic signed [31:0]      out_key_o,
  output logic        [31:0]      out_payload_o,
  output logic        [CNT_W-1:0] count_o
);

  logic [31:0] key_mem [DEPTH];
  logic [31:0] pay_mem [DEPTH];

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] idx_m1;
  logic [31:0]      key_q, pay_q;
  logic [31:0]      rkey_q, rpay_q;

  logic             done_q;
  logic [1:0]       status_q;
  logic [31:0]      okey_q, opay_q;
  logic [CNT_W-1:0] ocnt_q;

  logic             wr_en;
  logic [31:0]      wkey, wpay;

  assign idx_m1 = idx_q - CNT_W'(1);

  // Memory: the write goes to the index, the read comes from one below it.
  assign wr_en = cmd_i.shift_wr | cmd_i.new_wr;
  assign wkey  = cmd_i.shift_wr ? rkey_q : key_q;
  assign wpay  = cmd_i.shift_wr ? rpay_q : pay_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[idx_q[IDX_W-1:0]] <= wkey;
      pay_mem[idx_q[IDX_W-1:0]] <= wpay;
    end
    if (cmd_i.rd_en) begin
      rkey_q <= key_mem[idx_m1[IDX_W-1:0]];
      rpay_q <= pay_mem[idx_m1[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      key_q <= key_i;
      pay_q <= payload_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.ld_item) begin
      idx_d = count_q;
    end else if (cmd_i.shift_wr) begin
      idx_d = idx_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      done_q  <= cmd_i.res_done | cmd_i.res_full | cmd_i.res_empty | cmd_i.res_pop;
    end
  end

  // Result registers; the count shown is the one after the operation.
  always_ff @(posedge clk_i) begin
    okey_q   <= '0;
    opay_q   <= '0;
    status_q <= ST_DONE;
    ocnt_q   <= count_d;
    if (cmd_i.res_full) begin
      status_q <= ST_FULL;
    end else if (cmd_i.res_empty) begin
      status_q <= ST_EMPTY;
    end else if (cmd_i.res_pop) begin
      okey_q <= rkey_q;
      opay_q <= rpay_q;
    end
  end

  assign sts_o.full    = (count_q == DEPTH_CNT);
  assign sts_o.empty   = (count_q == '0);
  assign sts_o.idx_one = (idx_q == CNT_W'(1));
  assign sts_o.rd_le   = ($signed(rkey_q) <= $signed(key_q));

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign out_key_o     = $signed(okey_q);
  assign out_payload_o = opay_q;
  assign count_o       = ocnt_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_CNT)
    else $error("entry count above capacity");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == ST_FULL) |-> (ocnt_q == DEPTH_CNT))
    else $error("full status with a queue that is not full");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == ST_EMPTY) |-> (ocnt_q == '0))
    else $error("empty status with entries held");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift_wr |-> (idx_q != '0 && idx_q < DEPTH_CNT))
    else $error("shift outside the held entries");

endmodule

// File: hw/rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl: sequencer of the sorted priority queue
// Walks a push from the back of the queue towards the front, one entry per
// read and compare, and drives the single read of a pop.
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     op_i,
  output logic     busy_o,
  input  spq_sts_t sts_i,
  output spq_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_PUSH_RD  = 3'd1;
  localparam logic [2:0] S_PUSH_CMP = 3'd2;
  localparam logic [2:0] S_PUSH_WR  = 3'd3;
  localparam logic [2:0] S_POP_RD   = 3'd4;
  localparam logic [2:0] S_POP_OUT  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.ld_item = 1'b1;
          if (op_i == OP_PUSH) begin
            if (sts_i.full) begin
              cmd_o.res_full = 1'b1;
            end else if (sts_i.empty) begin
              state_d = S_PUSH_WR;
            end else begin
              state_d = S_PUSH_RD;
            end
          end else begin
            if (sts_i.empty) begin
              cmd_o.res_empty = 1'b1;
            end else begin
              state_d = S_POP_RD;
            end
          end
        end
      end
      S_PUSH_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_PUSH_CMP;
      end
      S_PUSH_CMP: begin
        if (sts_i.rd_le) begin
          cmd_o.shift_wr = 1'b1;
          state_d        = sts_i.idx_one ? S_PUSH_WR : S_PUSH_RD;
        end else begin
          cmd_o.new_wr   = 1'b1;
          cmd_o.cnt_inc  = 1'b1;
          cmd_o.res_done = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_PUSH_WR: begin
        cmd_o.new_wr   = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        cmd_o.res_done = 1'b1;
        state_d        = S_IDLE;
      end
      S_POP_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.cnt_dec = 1'b1;
        state_d       = S_POP_OUT;
      end
      S_POP_OUT: begin
        cmd_o.res_pop = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  a_ld_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ld_item |-> (state_q == S_IDLE))
    else $error("item captured while busy");

  a_pop_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP_RD) |=> (state_q == S_POP_OUT))
    else $error("pop read not followed by its result");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.shift_wr && cmd_o.new_wr))
    else $error("two memory writes in one cycle");

endmodule

// File: hw/rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue kept as a sorted array
// Holds up to DEPTH entries of signed key and 32-bit payload; a pop returns
// the smallest key, oldest first among equal keys.
// ----------------------------------------------------------------------------
// Usage: raise start_i with op_i, key_i and payload_i; the beat is taken at
// a rising edge where start_i is high and busy_o is low. op_i low pushes the
// key and payload, op_i high pops the entry with the smallest key (key_i and
// payload_i are then ignored). Every beat yields exactly one result beat:
// done_o is high for one cycle with status_o, out_key_o, out_payload_o and
// count_o, the count being the number of entries after the operation.
// A push on a full queue or a pop on an empty queue finishes at once: the
// result appears on the next cycle and busy_o never rises.
// A pop reads the entry memory once, then loads the result register. A push
// walks from the back of the queue towards the front through the single
// read port of the entry memory, with a read state and a compare state for
// each entry that moves back. When every held entry moves, a final write
// follows the last shift, then the result; when a larger key stops the
// walk, the new entry is written in the compare state after that read.
// The longest push fills a queue of DEPTH-1 entries.
// A new beat is taken in the cycle the result shows.
// Reset clears the count and the sequencer; the entry memory is not cleared,
// since only slots below the count are ever read. Results cannot be stalled.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    op_i,
  input  logic signed [31:0]      key_i,
  input  logic        [31:0]      payload_i,
  output logic                    done_o,
  output logic        [1:0]       status_o,
  output logic signed [31:0]      out_key_o,
  output logic        [31:0]      out_payload_o,
  output logic        [CNT_W-1:0] count_o
);

  // Command and status bundles between the sequencer and the datapath.
  spq_cmd_t cmd;
  spq_sts_t sts;

  // The sequencer decides, per cycle, which memory access and which counter
  // update the datapath performs.
  spq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (op_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  // The datapath holds the entries, the count and the result registers.
  spq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .key_i         (key_i),
    .payload_i     (payload_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .out_key_o     (out_key_o),
    .out_payload_o (out_payload_o),
    .count_o       (count_o)
  );

endmodule

// File: tb/sv/tb_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue: self-checking bench for the sorted priority queue
// Drives push and pop commands through the start/busy handshake. A scoreboard
// class keeps its own sorted copy of the queue, predicts every result beat
// and compares it field by field. The run covers empty and full queues,
// equal keys and key extremes, then random traffic with bursts and gaps.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue
  import spq_pkg::*;
;

  // Number of random command beats after the directed part.
  localparam int unsigned RANDOM_ITEMS = 1500;
  // Number of random beats between the points where the sender drains the queue.
  localparam int unsigned DRAIN_EVERY  = 400;
  // The longest command is a push that moves every entry of a queue holding
  // DEPTH-1 entries. The tail wait at the end covers that with some margin.
  localparam int unsigned TAIL_CYCLES  = 2 * DEPTH + 8;
  // Watchdog limit on cycles in which no beat is accepted and no result
  // shows. The slowest correct stretch is a full-length push after the
  // longest sender gap.
  localparam int unsigned STALL_LIMIT  = 2000;

  // One expected result beat.
  typedef struct {
    logic [1:0]        status;
    logic signed [31:0] key;
    logic [31:0]       payload;
    logic [CNT_W-1:0]  count;
  } spq_result_t;

  // The scoreboard holds a sorted copy of the queue. Slot 0 carries the
  // largest key and slot held-1 the smallest. Among equal keys the newest
  // entry sits nearest the front, so pops return equal keys oldest first.
  class spq_scoreboard;
    logic signed [31:0] slot_key [DEPTH];
    logic [31:0]        slot_payload [DEPTH];
    int unsigned        held;
    spq_result_t        due_q [$];
    int unsigned        errors;

    // Applies one accepted command to the copy and queues its result.
    function void note_beat(logic op, logic signed [31:0] key, logic [31:0] payload);
      spq_result_t r;
      int unsigned pos;
      int unsigned i;
      r.status  = ST_DONE;
      r.key     = '0;
      r.payload = '0;
      if (op == OP_PUSH) begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // The new entry goes in front of the first entry whose key is not
          // larger, which puts it ahead of every older entry with its key.
          pos = 0;
          while (pos < held && slot_key[pos] > key) pos++;
          for (i = held; i > pos; i--) begin
            slot_key[i]     = slot_key[i-1];
            slot_payload[i] = slot_payload[i-1];
          end
          slot_key[pos]     = key;
          slot_payload[pos] = payload;
          held++;
        end
      end else if (held == 0) begin
        r.status = ST_EMPTY;
      end else begin
        held--;
        r.key     = slot_key[held];
        r.payload = slot_payload[held];
      end
      r.count = CNT_W'(held);
      due_q.push_back(r);
    endfunction

    // Compares one result beat with the oldest expectation.
    function void check_result(logic [1:0] status, logic signed [31:0] key,
                               logic [31:0] payload, logic [CNT_W-1:0] count);
      spq_result_t r;
      if (due_q.size() == 0) begin
        $error("result beat with no command pending");
        errors++;
        return;
      end
      r = due_q.pop_front();
      if (status !== r.status) begin
        $error("status mismatch: expected %0d, got %0d", r.status, status);
        errors++;
      end
      if (key !== r.key) begin
        $error("out_key mismatch: expected %0d, got %0d", r.key, key);
        errors++;
      end
      if (payload !== r.payload) begin
        $error("out_payload mismatch: expected 0x%08h, got 0x%08h", r.payload, payload);
        errors++;
      end
      if (count !== r.count) begin
        $error("count mismatch: expected %0d, got %0d", r.count, count);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni    = 1'b0;
  logic                    start_i   = 1'b0;
  logic                    op_i      = OP_PUSH;
  logic signed [31:0]      key_i     = '0;
  logic        [31:0]      payload_i = '0;
  logic                    busy_o;
  logic                    done_o;
  logic        [1:0]       status_o;
  logic signed [31:0]      out_key_o;
  logic        [31:0]      out_payload_o;
  logic        [CNT_W-1:0] count_o;

  spq_scoreboard sb = new();
  int unsigned   stall_cycles = 0;

  sorted_priority_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .op_i          (op_i),
    .key_i         (key_i),
    .payload_i     (payload_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .out_key_o     (out_key_o),
    .out_payload_o (out_payload_o),
    .count_o       (count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Monitor. Everything the bench drives changes by nonblocking assignment,
  // so at the clock edge this block sees the values that the edge samples.
  // The result of the previous command is checked before the new command
  // is noted. The order does not matter for the expectation queue, but it
  // keeps the flow easy to follow.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        sb.check_result(status_o, out_key_o, out_payload_o, count_o);
      end else if (done_o !== 1'b0) begin
        $error("done_o is unknown");
        sb.errors++;
      end
      if (start_i && busy_o === 1'b0) begin
        sb.note_beat(op_i, key_i, payload_i);
      end
    end
  end

  // Watchdog. It counts cycles in which no beat moves either way.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && busy_o === 1'b0) || done_o === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Presents one command and returns at the edge that takes it. start_i
  // stays high on return, so a back-to-back command is not lowered and
  // raised again within one time step.
  task automatic send_beat(input logic op, input logic signed [31:0] key,
                           input logic [31:0] payload);
    start_i   <= 1'b1;
    op_i      <= op;
    key_i     <= key;
    payload_i <= payload;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  // Sender gap of a given number of cycles.
  task automatic idle_for(input int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Holds off until every pending result has come back. At least one edge
  // passes, so start_i is never driven twice in the same time step.
  task automatic wait_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.due_q.size() != 0);
  endtask

  // Keys lean towards a narrow band so that equal keys are common, with
  // the two extremes and fully random patterns mixed in.
  function automatic logic signed [31:0] choose_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: choose_key = $signed($urandom_range(0, 8)) - 32'sd4;
      4:          choose_key = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default:    choose_key = $urandom;
    endcase
  endfunction

  function automatic logic [31:0] choose_payload();
    case ($urandom_range(0, 15))
      0:       choose_payload = 32'h0000_0000;
      1:       choose_payload = 32'hffff_ffff;
      default: choose_payload = $urandom;
    endcase
  endfunction

  initial begin
    logic signed [31:0] fill_keys [16] = '{
      32'sd0, -32'sd1, 32'sd1, 32'sd5, 32'sd5, 32'sd5, -32'sd5, 32'sh7fffffff,
      32'sh80000000, 32'sd0, 32'sd100, -32'sd100, 32'sd7, 32'sd7, 32'sd3, 32'sd2
    };
    logic        op;
    int unsigned sent;
    int unsigned burst;
    int unsigned push_pct;
    int unsigned next_drain;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A pop on the empty queue, then both key extremes with
    // a repeated key so that pops must return the older of the pair first.
    // The third pop takes the last entry and must bring the count to zero.
    send_beat(OP_POP, $urandom, $urandom);
    send_beat(OP_PUSH, 32'sh7fffffff, 32'h0000_0000);
    send_beat(OP_PUSH, 32'sh80000000, 32'hffff_ffff);
    send_beat(OP_PUSH, 32'sh7fffffff, 32'h0000_0001);
    repeat (3) send_beat(OP_POP, $urandom, $urandom);
    send_beat(OP_POP, 32'sh7fffffff, 32'hffff_ffff);

    // Fill the queue to capacity with a spread of keys, some repeated, and
    // then push once more so that the full case is hit.
    for (int unsigned i = 0; i < DEPTH && i < $size(fill_keys); i++) begin
      send_beat(OP_PUSH, fill_keys[i], 32'ha5a5_0000 | i);
    end
    send_beat(OP_PUSH, 32'sd9, 32'h5a5a_5a5a);
    wait_drained();

    // Random part. The share of pushes shifts from time to time, so the
    // queue drifts between empty and full and both edge cases recur. The
    // sender runs in bursts, with either no gap or a short random one.
    sent       = 0;
    push_pct   = 50;
    next_drain = DRAIN_EVERY;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
        send_beat(op, choose_key(), choose_payload());
        sent++;
      end
      if (sent >= next_drain) begin
        wait_drained();
        next_drain += DRAIN_EVERY;
      end else if ($urandom_range(0, 2) != 0) begin
        idle_for($urandom_range(1, 8));
      end
    end

    // Let the last results come back, then allow for the longest push.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sorted_priority_queue.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_dp.sv
hw/rtl/spq_ctrl.sv
hw/rtl/sorted_priority_queue.sv
tb/sv/tb_sorted_priority_queue.sv
